/* design/spi_bridge_command_processor_core_macros.svh */
// Assertion helpers
`ifndef SPI_BRIDGE_COMMAND_PROCESSOR_CORE_MACROS_SVH
`define SPI_BRIDGE_COMMAND_PROCESSOR_CORE_MACROS_SVH

`define SBCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define SBCP_ASSERT_IMP(label, cond, cons, msg) \
  `SBCP_ASSERT(label, (cond) |-> (cons), msg)

`endif

/* design/sbcp_pkg.sv */
package sbcp_pkg;

  localparam int unsigned BufferDepthDef = 4096;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEADER, PH_FILL, PH_WRITE, PH_READ, PH_SEND, PH_BULK_HOST, PH_BULK_SPI
  } phase_e;

  typedef enum logic [1:0] {
    OP_HOST = 2'd0, OP_SPI = 2'd1, OP_READY = 2'd2, OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0, ACT_HOST = 2'd1, ACT_SPI = 2'd2, ACT_EXIT = 2'd3
  } act_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } item_t;

  // result of one item: up to four bytes plus settings
  typedef struct packed {
    logic [2:0]  cnt;
    logic [3:0][9:0] res;   // {action, byte} per result
    logic        sel;
    logic [4:0]  speed;
    logic [3:0]  clk;
    logic [3:0]  periph;
  } job_t;

  function automatic logic [4:0] speed_lut(input logic [2:0] idx);
    logic [4:0] r;
    case (idx)
      3'd0: r = 5'h00;
      3'd1: r = 5'h18;
      3'd2: r = 5'h1C;
      3'd3: r = 5'h1D;
      3'd4: r = 5'h03;
      3'd5: r = 5'h08;
      3'd6: r = 5'h10;
      default: r = 5'h18;
    endcase
    return r;
  endfunction

endpackage

/* design/sbcp_front.sv */
module sbcp_front
  import sbcp_pkg::*;
#(
  parameter int unsigned BufferDepth = BufferDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  job_valid_o,
  input  logic  job_ready_i,
  output job_t  job_o
);

  localparam int unsigned AW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;

  logic [7:0] mem [BufferDepth];

  phase_e      phase_q, phase_d;
  logic [1:0]  hidx_q, hidx_d;
  logic [15:0] wcnt_q, wcnt_d, rcnt_q, rcnt_d, pos_q, pos_d;
  logic        framed_q, framed_d, sel_q, sel_d;
  logic [2:0]  spd_q, spd_d;
  logic [3:0]  clk_q, clk_d, per_q, per_d;

  // store access: read port registered; a pending fetch stalls input acceptance
  logic        rd_pend_q, rd_pend_d;
  logic        rd_req;
  logic [15:0] rd_addr;
  logic [7:0]  rd_data_q;
  logic        wr_en;
  logic [15:0] wr_addr;
  logic [7:0]  wr_data;

  logic        fire;
  logic [2:0]  n;
  logic [3:0][9:0] res;
  logic [15:0] pos_inc;
  logic [15:0] wv, rv;

  assign in_ready_o = !rd_pend_q && (!job_valid_o || job_ready_i);
  assign fire = in_valid_i && in_ready_o;
  assign pos_inc = pos_q + 16'd1;

  // store fetch: the byte that the accepted item's own SPI/host result needs
  always_comb begin
    rd_req  = 1'b0;
    rd_addr = pos_q;
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = in_item_i.data;
    if (fire) begin
      if (phase_q == PH_FILL && in_item_i.op == OP_HOST) begin
        wr_en = 1'b1;
        if (pos_inc >= wcnt_q) begin
          rd_req = 1'b1;
          rd_addr = '0;
        end
      end else if (phase_q == PH_READ && in_item_i.op == OP_SPI) begin
        wr_en = 1'b1;
      end else if (phase_q == PH_WRITE && in_item_i.op == OP_SPI) begin
        rd_req = 1'b1;
        rd_addr = pos_inc;
      end else if (phase_q == PH_SEND && in_item_i.op == OP_READY) begin
        rd_req = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_addr < 16'(BufferDepth)) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (rd_req) begin
      rd_data_q <= (rd_addr < 16'(BufferDepth)) ? mem[rd_addr[AW-1:0]] : 8'h00;
    end
  end

  // held item while its store byte is fetched
  item_t held_q;
  logic  go;
  item_t cur;
  assign go  = rd_pend_q || (fire && !rd_req);
  assign cur = rd_pend_q ? held_q : in_item_i;
  assign rd_pend_d = fire && rd_req;

  always_ff @(posedge clk_i) begin
    if (fire) held_q <= in_item_i;
  end

  always_comb begin
    phase_d = phase_q; hidx_d = hidx_q; wcnt_d = wcnt_q; rcnt_d = rcnt_q;
    pos_d = pos_q; framed_d = framed_q; sel_d = sel_q; spd_d = spd_q;
    clk_d = clk_q; per_d = per_q;
    n = 3'd0;
    res = '0;
    wv = wcnt_q;
    rv = rcnt_q;
    if (go) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (cur.op == OP_HOST) begin
            n = 3'd1;
            res[0] = {ACT_HOST, 8'd1};
            unique case (cur.data[7:4])
              4'h0: begin
                case (cur.data[3:0])
                  4'h0: res[0] = {ACT_EXIT, 8'd0};
                  4'h1: begin
                    n = 3'd4;
                    res[0] = {ACT_HOST, 8'h53};
                    res[1] = {ACT_HOST, 8'h50};
                    res[2] = {ACT_HOST, 8'h49};
                    res[3] = {ACT_HOST, 8'h31};
                  end
                  4'h2: sel_d = 1'b0;
                  4'h3: sel_d = 1'b1;
                  4'hD, 4'hE: ;
                  4'h4, 4'h5: begin
                    n = 3'd0;
                    framed_d = !cur.data[0];
                    hidx_d = '0; wcnt_d = '0; rcnt_d = '0;
                    phase_d = PH_HEADER;
                  end
                  default: res[0] = {ACT_HOST, 8'd0};
                endcase
              end
              4'h1: begin
                pos_d = {12'd0, cur.data[3:0]} + 16'd1;
                phase_d = PH_BULK_HOST;
              end
              4'h4: per_d = cur.data[3:0];
              4'h6: begin
                spd_d = cur.data[2:0];
                sel_d = 1'b1;
              end
              4'h8: begin
                clk_d = {!cur.data[3], cur.data[0], cur.data[1], cur.data[2]};
                sel_d = 1'b1;
              end
              default: res[0] = {ACT_HOST, 8'd0};
            endcase
          end
        end
        PH_HEADER: begin
          if (cur.op == OP_HOST) begin
            case (hidx_q)
              2'd0: wv = {cur.data, 8'd0};
              2'd1: wv = wcnt_q | {8'd0, cur.data};
              2'd2: rv = {cur.data, 8'd0};
              default: rv = rcnt_q | {8'd0, cur.data};
            endcase
            wcnt_d = wv; rcnt_d = rv;
            hidx_d = hidx_q + 2'd1;
            if (hidx_q == 2'd3) begin
              if (wv > 16'(BufferDepth) || rv > 16'(BufferDepth)) begin
                phase_d = PH_IDLE;
                n = 3'd1;
                res[0] = {ACT_HOST, 8'd0};
              end else if (wv != 16'd0) begin
                pos_d = '0;
                phase_d = PH_FILL;
              end else begin
                if (framed_q) sel_d = 1'b0;
                pos_d = '0;
                n = 3'd1;
                if (rv != 16'd0) begin
                  phase_d = PH_READ;
                  res[0] = {ACT_SPI, 8'hFF};
                end else begin
                  if (framed_q) sel_d = 1'b1;
                  phase_d = PH_IDLE;
                  res[0] = {ACT_HOST, 8'd1};
                end
              end
            end
          end
        end
        PH_FILL: begin
          if (cur.op == OP_HOST) begin
            pos_d = pos_inc;
            if (pos_inc >= wcnt_q) begin
              if (framed_q) sel_d = 1'b0;
              pos_d = '0;
              phase_d = PH_WRITE;
              n = 3'd1;
              // single-byte write: the byte is still on its way into the store
              res[0] = {ACT_SPI, (wcnt_q == 16'd1) ? cur.data : rd_data_q};
            end
          end
        end
        PH_WRITE: begin
          if (cur.op == OP_SPI) begin
            n = 3'd1;
            pos_d = pos_inc;
            if (pos_inc < wcnt_q) begin
              res[0] = {ACT_SPI, rd_data_q};
            end else begin
              pos_d = '0;
              if (rcnt_q != 16'd0) begin
                phase_d = PH_READ;
                res[0] = {ACT_SPI, 8'hFF};
              end else begin
                if (framed_q) sel_d = 1'b1;
                phase_d = PH_IDLE;
                res[0] = {ACT_HOST, 8'd1};
              end
            end
          end
        end
        PH_READ: begin
          if (cur.op == OP_SPI) begin
            n = 3'd1;
            pos_d = pos_inc;
            if (pos_inc < rcnt_q) begin
              res[0] = {ACT_SPI, 8'hFF};
            end else begin
              if (framed_q) sel_d = 1'b1;
              pos_d = '0;
              phase_d = PH_SEND;
              res[0] = {ACT_HOST, 8'd1};
            end
          end
        end
        PH_SEND: begin
          if (cur.op == OP_READY) begin
            n = 3'd1;
            res[0] = {ACT_HOST, rd_data_q};
            pos_d = pos_inc;
            if (pos_inc >= rcnt_q) phase_d = PH_IDLE;
          end
        end
        PH_BULK_HOST: begin
          if (cur.op == OP_HOST) begin
            n = 3'd1;
            res[0] = {ACT_SPI, cur.data};
            phase_d = PH_BULK_SPI;
          end
        end
        PH_BULK_SPI: begin
          if (cur.op == OP_SPI) begin
            n = 3'd1;
            res[0] = {ACT_HOST, cur.data};
            pos_d = pos_q - 16'd1;
            phase_d = (pos_q == 16'd1) ? PH_IDLE : PH_BULK_HOST;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  logic job_v_q;
  job_t job_q;
  assign job_valid_o = job_v_q;
  assign job_o = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; hidx_q <= '0; wcnt_q <= '0; rcnt_q <= '0; pos_q <= '0;
      framed_q <= 1'b0; sel_q <= 1'b1; spd_q <= 3'd1; clk_q <= 4'b1010; per_q <= '0;
      rd_pend_q <= 1'b0; job_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d; hidx_q <= hidx_d; wcnt_q <= wcnt_d; rcnt_q <= rcnt_d;
      pos_q <= pos_d; framed_q <= framed_d; sel_q <= sel_d; spd_q <= spd_d;
      clk_q <= clk_d; per_q <= per_d;
      rd_pend_q <= rd_pend_d;
      if (go && n != 3'd0) job_v_q <= 1'b1;
      else if (job_ready_i) job_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && n != 3'd0) begin
      job_q.cnt <= n; job_q.res <= res; job_q.sel <= sel_d;
      job_q.speed <= speed_lut(spd_d); job_q.clk <= clk_d; job_q.periph <= per_d;
    end
  end

  `include "spi_bridge_command_processor_core_macros.svh"
  `SBCP_ASSERT_IMP(a_pend_once, rd_pend_q, !rd_pend_d, "fetch stall repeats")
  `SBCP_ASSERT_IMP(a_pend_noaccept, rd_pend_q, !in_ready_o, "accept during fetch")
  `SBCP_ASSERT_IMP(a_job_cnt, job_v_q, job_q.cnt != 3'd0 && job_q.cnt <= 3'd4, "bad count")

endmodule

/* design/sbcp_queue.sv */
module sbcp_queue
  import sbcp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  job_t in_job_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output job_t out_job_o
);

  job_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_job_o   = slot_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wp_q] <= in_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* design/sbcp_back.sv */
module sbcp_back
  import sbcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic [1:0] idx_q;
  logic       done;
  logic [9:0] r;

  assign r = job_i.res[idx_q];
  assign m_axis_tvalid = job_valid_i;
  assign done = ({1'b0, idx_q} + 3'd1) == job_i.cnt;
  assign m_axis_tlast = done;
  assign job_ready_o = m_axis_tready && done;
  assign m_axis_tuser = r[9:8];
  assign m_axis_tdata = {2'b00, job_i.periph, job_i.clk[3], job_i.clk[2], job_i.clk[1],
                         job_i.clk[0], job_i.speed, job_i.sel, r[7:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (job_valid_i && m_axis_tready) begin
      idx_q <= done ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

/* design/spi_bridge_command_processor_core.sv */
// Host-to-SPI command processor.
// Input stream s_axis: one event item per transfer, op in tuser[1:0], byte in tdata[7:0].
//   op 0 host byte, 1 SPI exchange done (MISO byte), 2 host ready for next reply byte.
// Output stream m_axis: zero to four result items per input item, tlast on the final one.
//   tuser carries the action; tdata carries byte, chip select level, speed code, clock
//   settings and the peripheral nibble as they stand after the event.
// Each result is registered in the front, then in the queue, before it reaches the output.
// Items that read the byte store (first write byte, later write bytes, host replay)
// wait for the registered store read before their result is formed.
// Throughput: one item per cycle on the input unless a store read or back-pressure stalls it,
// one result per cycle on the output while ready; an item with k results takes k transfers.
// A two-entry queue sits between the front and the output sequencer, so the input
// keeps accepting while the receiver stalls until the queue and front register fill.
// Reset: asynchronous, active low; idle, select high, speed index 1, open drain,
// clock edge active-to-idle. The byte store is not cleared.
module spi_bridge_command_processor_core
  import sbcp_pkg::*;
#(
  parameter int unsigned BufferDepth = BufferDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0], select_level[8], speed_code[13:9], idle_high[14],
  // edge_active_to_idle[15], sample_at_end[16], open_drain[17], peripheral_bits[21:18]
  output logic [23:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // action[1:0]
  output logic        m_axis_tlast
);

  item_t it;
  logic  fj_v, fj_r, qj_v, qj_r;
  job_t  fj, qj;

  assign it.op   = s_axis_tuser;
  assign it.data = s_axis_tdata;

  sbcp_front #(.BufferDepth(BufferDepth)) u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_item_i(it), .job_valid_o(fj_v), .job_ready_i(fj_r), .job_o(fj)
  );

  sbcp_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(fj_v), .in_ready_o(fj_r), .in_job_i(fj),
    .out_valid_o(qj_v), .out_ready_i(qj_r), .out_job_o(qj)
  );

  sbcp_back u_back (
    .clk_i, .rst_ni, .job_valid_i(qj_v), .job_ready_o(qj_r), .job_i(qj),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

endmodule

/* tb/sv/tb_spi_bridge_command_processor_core.sv */
`timescale 1ns / 100ps

module tb_spi_bridge_command_processor_core;
  import sbcp_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned Limit = 400000;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] byt;
    logic       last;
    logic       sel;
    logic [4:0] speed;
    logic       ckp;
    logic       cke;
    logic       smp;
    logic       od;
    logic [3:0] periph;
  } reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  spi_bridge_command_processor_core #(.BufferDepth(Depth)) i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  // bridge state
  phase_e      ph;
  logic [1:0]  hdr_idx;
  logic [15:0] wr_cnt, rd_cnt, pos;
  logic        framed;
  logic [7:0]  store [Depth];
  logic        sel_pin;
  logic [2:0]  spd_idx;
  logic [3:0]  clk_cfg;
  logic [3:0]  periph;

  reply_t      reply_q [$];
  reply_t      pend [$];
  int          errors;
  int unsigned cycles;
  int unsigned n_sent;
  bit          done;

  function automatic logic [4:0] speed_code(input logic [2:0] i);
    case (i)
      3'd0: return 5'h00;
      3'd1: return 5'h18;
      3'd2: return 5'h1C;
      3'd3: return 5'h1D;
      3'd4: return 5'h03;
      3'd5: return 5'h08;
      3'd6: return 5'h10;
      default: return 5'h18;
    endcase
  endfunction

  task automatic emit(input act_e a, input logic [7:0] b);
    reply_t r;
    r = '0;
    r.act = a;
    r.byt = b;
    pend.push_back(r);
  endtask

  task automatic start_reads();
    pos = 0;
    if (rd_cnt > 0) begin
      ph = PH_READ;
      emit(ACT_SPI, 8'hFF);
    end else begin
      if (framed) sel_pin = 1'b1;
      ph = PH_IDLE;
      emit(ACT_HOST, 8'd1);
    end
  endtask

  task automatic start_writes();
    if (framed) sel_pin = 1'b0;
    pos = 0;
    if (wr_cnt > 0) begin
      ph = PH_WRITE;
      emit(ACT_SPI, store[0]);
    end else begin
      start_reads();
    end
  endtask

  task automatic run_command(input logic [7:0] b);
    case (b[7:4])
      4'h0: begin
        case (b[3:0])
          4'h0: emit(ACT_EXIT, 8'd0);
          4'h1: begin
            emit(ACT_HOST, "S");
            emit(ACT_HOST, "P");
            emit(ACT_HOST, "I");
            emit(ACT_HOST, "1");
          end
          4'h2: begin sel_pin = 1'b0; emit(ACT_HOST, 8'd1); end
          4'h3: begin sel_pin = 1'b1; emit(ACT_HOST, 8'd1); end
          4'hD, 4'hE: emit(ACT_HOST, 8'd1);
          4'h4, 4'h5: begin
            framed = (b[3:0] == 4'h4);
            hdr_idx = 0;
            wr_cnt = 0;
            rd_cnt = 0;
            ph = PH_HEADER;
          end
          default: emit(ACT_HOST, 8'd0);
        endcase
      end
      4'h1: begin
        pos = 16'(b[3:0]) + 16'd1;
        ph = PH_BULK_HOST;
        emit(ACT_HOST, 8'd1);
      end
      4'h4: begin periph = b[3:0]; emit(ACT_HOST, 8'd1); end
      4'h6: begin spd_idx = b[2:0]; sel_pin = 1'b1; emit(ACT_HOST, 8'd1); end
      4'h8: begin
        clk_cfg = {~b[3], b[0], b[1], b[2]};
        sel_pin = 1'b1;
        emit(ACT_HOST, 8'd1);
      end
      default: emit(ACT_HOST, 8'd0);
    endcase
  endtask

  task automatic predict_bridge(input logic [1:0] op, input logic [7:0] d);
    pend.delete();
    if (op == OP_HOST) begin
      case (ph)
        PH_IDLE: run_command(d);
        PH_HEADER: begin
          case (hdr_idx)
            2'd0: wr_cnt = {d, 8'h00};
            2'd1: wr_cnt = wr_cnt | 16'(d);
            2'd2: rd_cnt = {d, 8'h00};
            default: rd_cnt = rd_cnt | 16'(d);
          endcase
          hdr_idx = hdr_idx + 2'd1;
          if (hdr_idx == 0) begin
            if (wr_cnt > Depth || rd_cnt > Depth) begin
              ph = PH_IDLE;
              emit(ACT_HOST, 8'd0);
            end else if (wr_cnt > 0) begin
              pos = 0;
              ph = PH_FILL;
            end else begin
              start_writes();
            end
          end
        end
        PH_FILL: begin
          store[pos] = d;
          pos++;
          if (pos >= wr_cnt) start_writes();
        end
        PH_BULK_HOST: begin ph = PH_BULK_SPI; emit(ACT_SPI, d); end
        default: ;
      endcase
    end else if (op == OP_SPI) begin
      case (ph)
        PH_WRITE: begin
          pos++;
          if (pos < wr_cnt) emit(ACT_SPI, store[pos]);
          else start_reads();
        end
        PH_READ: begin
          store[pos] = d;
          pos++;
          if (pos < rd_cnt) begin
            emit(ACT_SPI, 8'hFF);
          end else begin
            if (framed) sel_pin = 1'b1;
            pos = 0;
            ph = PH_SEND;
            emit(ACT_HOST, 8'd1);
          end
        end
        PH_BULK_SPI: begin
          pos--;
          ph = (pos == 0) ? PH_IDLE : PH_BULK_HOST;
          emit(ACT_HOST, d);
        end
        default: ;
      endcase
    end else if (op == OP_READY && ph == PH_SEND) begin
      emit(ACT_HOST, store[pos]);
      pos++;
      if (pos >= rd_cnt) ph = PH_IDLE;
    end
    foreach (pend[k]) begin
      pend[k].last   = (k == pend.size() - 1);
      pend[k].sel    = sel_pin;
      pend[k].speed  = speed_code(spd_idx);
      pend[k].ckp    = clk_cfg[0];
      pend[k].cke    = clk_cfg[1];
      pend[k].smp    = clk_cfg[2];
      pend[k].od     = clk_cfg[3];
      pend[k].periph = periph;
      reply_q.push_back(pend[k]);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver stalls in a rotating pattern, with calm stretches
  logic [15:0] stall_pat;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles[9:8] == 2'd3) m_axis_tready <= 1'b1;
    else begin
      m_axis_tready <= stall_pat[0];
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    if (cycles[11:0] == 12'hFFF) stall_pat <= 16'($urandom) | 16'h0101;
  end

  always @(posedge clk_i) begin
    reply_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[8],
             m_axis_tdata[13:9], m_axis_tdata[14], m_axis_tdata[15], m_axis_tdata[16],
             m_axis_tdata[17], m_axis_tdata[21:18]};
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  task automatic send(input logic [1:0] op, input logic [7:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_bridge(op, d);
    n_sent++;
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // directed table; known replies checked by the predictor
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] d;
  } row_t;

  row_t dir_tab [] = '{
    '{OP_HOST, 8'h01}, '{OP_HOST, 8'h02}, '{OP_HOST, 8'h03}, '{OP_HOST, 8'h0D},
    '{OP_HOST, 8'h0E}, '{OP_HOST, 8'h0F}, '{OP_HOST, 8'h4F}, '{OP_HOST, 8'h67},
    '{OP_HOST, 8'h8F}, '{OP_HOST, 8'h80}, '{OP_HOST, 8'hFF}, '{OP_SPI, 8'h00},
    '{OP_READY, 8'h00}, '{OP_NONE, 8'hFF}, '{OP_HOST, 8'h05}, '{OP_HOST, 8'hFF},
    '{OP_HOST, 8'hFF}, '{OP_HOST, 8'h00}, '{OP_HOST, 8'h00}, '{OP_HOST, 8'h04},
    '{OP_HOST, 8'h00}, '{OP_HOST, 8'h00}, '{OP_HOST, 8'h00}, '{OP_HOST, 8'h00},
    '{OP_HOST, 8'h00}
  };

  task automatic transfer(input logic [7:0] cmd);
    int nw, nr;
    nw = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
    nr = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
    if ($urandom_range(0, 15) == 0) nw = Depth;
    send(OP_HOST, cmd);
    send(OP_HOST, 8'(nw >> 8));
    send(OP_HOST, 8'(nw));
    send(OP_HOST, 8'(nr >> 8));
    send(OP_HOST, 8'(nr));
    repeat (nw) send(OP_HOST, 8'($urandom));
    if ($urandom_range(0, 5) == 0) send(OP_READY, 8'($urandom));
    repeat (nw) send(OP_SPI, 8'($urandom));
    repeat (nr) send(OP_SPI, 8'($urandom));
    repeat (nr) send(OP_READY, 8'($urandom));
  endtask

  initial begin
    logic [7:0] c;
    errors = 0;
    cycles = 0;
    n_sent = 0;
    done = 0;
    stall_pat = 16'hA5F3;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    ph = PH_IDLE; hdr_idx = 0; wr_cnt = 0; rd_cnt = 0; pos = 0; framed = 0;
    sel_pin = 1'b1; spd_idx = 3'd1; clk_cfg = 4'b1010; periph = 4'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // exit right after reset, checked before the result can leave the block
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= OP_HOST;
    s_axis_tdata  <= 8'h00;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_bridge(OP_HOST, 8'h00);
    n_sent++;
    if (reply_q[0] != {ACT_EXIT, 8'h00, 1'b1, 1'b1, 5'h18, 4'b0101, 4'h0}) begin
      $display("%0t: reset reply expected exit/default settings actual %h", $time, reply_q[0]);
      errors++;
    end
    foreach (dir_tab[i]) send(dir_tab[i].op, dir_tab[i].d);
    s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    while (n_sent < 210) begin
      case ($urandom_range(0, 9))
        0, 1, 2: transfer($urandom_range(0, 1) ? 8'h04 : 8'h05);
        3, 4: begin
          c = 8'h10 | 8'($urandom_range(0, 15));
          send(OP_HOST, c);
          repeat (c[3:0] + 1) begin
            send(OP_HOST, 8'($urandom));
            send(OP_SPI, 8'($urandom));
          end
        end
        5: send(2'($urandom), 8'($urandom));
        default: begin
          c = 8'($urandom);
          if (c inside {8'h04, 8'h05} || c[7:4] == 4'h1) c = 8'h01;
          send(OP_HOST, c);
        end
      endcase
    end
    s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    done = 1;
    if (errors == 0 && reply_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    wait (cycles >= Limit);
    if (!done) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
